>>> rtl/core/pcb_pkg.sv
// Package: shared types, command codes and arithmetic helpers for the blend unit.
`timescale 1ns / 1ps

package pcb_pkg;

  typedef enum logic [1:0] {
    CmdSolid = 2'd0,
    CmdTexel = 2'd1,
    CmdTint  = 2'd2,
    CmdGlyph = 2'd3
  } cmd_e;

  typedef logic [31:0] pixel_t;

  localparam logic [7:0] AlphaOpaque = 8'hff;
  localparam logic [7:0] AlphaClear  = 8'h00;

  // floor(x / 255) for x up to 255 * 255; exact over that range
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [15:0] t;
    t = x + {8'd0, x[15:8]} + 16'd1;
    return t[15:8];
  endfunction

  // script colour ARGB -> framebuffer byte order, alpha 0 reads as opaque
  function automatic pixel_t argb_to_fb(input logic [31:0] c);
    logic [7:0] a;
    a = (c[31:24] == AlphaClear) ? AlphaOpaque : c[31:24];
    return {a, c[7:0], c[15:8], c[23:16]};
  endfunction

endpackage

>>> rtl/core/pcb_if.sv
// Interfaces: request channel into the blend unit and result channel out of it.
`timescale 1ns / 1ps

interface pcb_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [31:0] dest_pixel;
  logic [31:0] texel;
  logic [31:0] color;
  logic [7:0]  coverage;

  modport source (output valid, command, dest_pixel, texel, color, coverage, input ready);
  modport sink   (input valid, command, dest_pixel, texel, color, coverage, output ready);
endinterface

interface pcb_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] pixel_out;
  logic        written;

  modport source (output valid, pixel_out, written, input ready);
  modport sink   (input valid, pixel_out, written, output ready);
endinterface

>>> rtl/core/pcb_mix.sv
// One colour channel of the source-over blend: registered weighted sum, then /255.
`timescale 1ns / 1ps

module pcb_mix (
  input  logic       clk_i,
  input  logic       en_i,
  input  logic [7:0] src_i,
  input  logic [7:0] dst_i,
  input  logic [7:0] alpha_i,
  output logic [7:0] mix_o
);
  import pcb_pkg::*;

  logic [15:0] sum_d, sum_q;
  logic [15:0] src_w, dst_w;
  logic [7:0]  inv_alpha;

  assign inv_alpha = AlphaOpaque - alpha_i;
  assign src_w     = 16'(src_i * alpha_i);
  assign dst_w     = 16'(dst_i * inv_alpha);
  // at most 255 * 255, fits 16 bits
  assign sum_d     = src_w + dst_w;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sum_q <= sum_d;
    end
  end

  assign mix_o = div255(sum_q);

endmodule

>>> rtl/core/pixel_compositing_blend_unit.sv
// Top level: four-stage pipelined source-over compositor for 8-bit RGBA pixels.
`timescale 1ns / 1ps
//
//  Channel  Dir  Handshake          Payload
//  -------  ---  -----------------  -------------------------------------------
//  in_i     in   valid / ready      command, dest_pixel, texel, color, coverage
//  out_o    out  valid / ready      pixel_out, written
//
//  One request per clock while out_o.ready is high; one result each, in order.
//  Four register stages: alpha product, /255 and source select, channel
//  products, /255 and final select. out_o.valid comes from the last stage's
//  valid bit: a result is offered once its request has passed every stage.
//  Each stage holds its own valid bit and advances when it is empty or the
//  next stage moves, so bubbles close up and a stall drops nothing.
//  Reset clears the valid bits only; payload registers are not reset.
//
module pixel_compositing_blend_unit (
  input  logic      clk_i,
  input  logic      rst_ni,
  pcb_in_if.sink    in_i,
  pcb_out_if.source out_o
);
  import pcb_pkg::*;

  // stage enables, computed back to front
  logic en1, en2, en3, en4;

  logic v1_q, v2_q, v3_q, v4_q;

  // stage 1: packed colour and the alpha product for tint / glyph modes
  cmd_e        cmd1_q;
  pixel_t      dst1_q, tex1_q, col1_q;
  logic [15:0] prod1_q;
  pixel_t      col_fb;
  logic [7:0]  fac;
  logic [15:0] prod1_d;

  // stage 2: source pixel formed
  pixel_t      dst2_q, src2_d, src2_q;
  logic [7:0]  scl_alpha;

  // stage 3: channel sums live in pcb_mix; the top keeps the bypass data
  pixel_t      dst3_q, src3_q;
  logic [7:0]  mix_r, mix_g, mix_b;

  // stage 4: output register
  pixel_t      pix4_d, pix4_q;
  logic        wr4_d, wr4_q;

  assign en4 = !v4_q || out_o.ready;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;

  assign in_i.ready = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_i.valid;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
    end
  end

  // ---- stage 1 ----
  assign col_fb  = argb_to_fb(in_i.color);
  // tint scales the texel alpha, glyph the coverage; other modes ignore it
  assign fac     = (cmd_e'(in_i.command) == CmdGlyph) ? in_i.coverage : in_i.texel[31:24];
  assign prod1_d = 16'(fac * col_fb[31:24]);

  always_ff @(posedge clk_i) begin
    if (en1) begin
      cmd1_q  <= cmd_e'(in_i.command);
      dst1_q  <= in_i.dest_pixel;
      tex1_q  <= in_i.texel;
      col1_q  <= col_fb;
      prod1_q <= prod1_d;
    end
  end

  // ---- stage 2 ----
  assign scl_alpha = div255(prod1_q);

  always_comb begin
    unique case (cmd1_q)
      CmdSolid: src2_d = col1_q;
      CmdTexel: src2_d = tex1_q;
      CmdTint,
      CmdGlyph: src2_d = {scl_alpha, col1_q[23:0]};
      default:  src2_d = col1_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en2) begin
      dst2_q <= dst1_q;
      src2_q <= src2_d;
    end
  end

  // ---- stage 3 ----
  pcb_mix u_mix_r (
    .clk_i   (clk_i),
    .en_i    (en3),
    .src_i   (src2_q[7:0]),
    .dst_i   (dst2_q[7:0]),
    .alpha_i (src2_q[31:24]),
    .mix_o   (mix_r)
  );

  pcb_mix u_mix_g (
    .clk_i   (clk_i),
    .en_i    (en3),
    .src_i   (src2_q[15:8]),
    .dst_i   (dst2_q[15:8]),
    .alpha_i (src2_q[31:24]),
    .mix_o   (mix_g)
  );

  pcb_mix u_mix_b (
    .clk_i   (clk_i),
    .en_i    (en3),
    .src_i   (src2_q[23:16]),
    .dst_i   (dst2_q[23:16]),
    .alpha_i (src2_q[31:24]),
    .mix_o   (mix_b)
  );

  always_ff @(posedge clk_i) begin
    if (en3) begin
      dst3_q <= dst2_q;
      src3_q <= src2_q;
    end
  end

  // ---- stage 4 ----
  // transparent source keeps the destination, opaque source replaces it,
  // anything between takes the blend with alpha forced opaque
  always_comb begin
    wr4_d = (src3_q[31:24] != AlphaClear);
    priority if (src3_q[31:24] == AlphaClear) begin
      pix4_d = dst3_q;
    end else if (src3_q[31:24] == AlphaOpaque) begin
      pix4_d = src3_q;
    end else begin
      pix4_d = {AlphaOpaque, mix_b, mix_g, mix_r};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en4) begin
      pix4_q <= pix4_d;
      wr4_q  <= wr4_d;
    end
  end

  assign out_o.valid     = v4_q;
  assign out_o.pixel_out = pix4_q;
  assign out_o.written   = wr4_q;

endmodule

>>> rtl/core/pcb_checker.sv
// Checker: port-level assertions for the blend unit, bound to the top level.
`timescale 1ns / 1ps

module pcb_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [31:0] pixel_out_i,
  input logic        written_i
);
  import pcb_pkg::*;

  logic       in_acc, out_acc;
  logic [2:0] cnt_d, cnt_q;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  always_comb begin
    cnt_d = cnt_q;
    if (in_acc && !out_acc) cnt_d = cnt_q + 3'd1;
    if (!in_acc && out_acc) cnt_d = cnt_q - 3'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 3'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // a waiting result holds still
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(pixel_out_i) && $stable(written_i))
    else $error("result changed while stalled");

  // a written pixel always leaves opaque alpha
  a_wr_opaque: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && written_i |-> pixel_out_i[31:24] == AlphaOpaque)
    else $error("written pixel without opaque alpha");

  // the input only blocks when the pipeline is full behind a stalled result
  a_back_press: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i && !out_ready_i && cnt_q == 3'd4)
    else $error("input blocked without a full stalled pipeline");

  // never more requests in flight than pipeline stages
  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 3'd4)
    else $error("too many requests in flight");

  // no result without a request behind it
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> cnt_q != 3'd0)
    else $error("result with no outstanding request");

endmodule

bind pixel_compositing_blend_unit pcb_checker u_pcb_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .pixel_out_i (out_o.pixel_out),
  .written_i   (out_o.written)
);

>>> tb/pcb_blend_checker.sv
// Checker: watches both channels, predicts each blended pixel and compares results in order.
`timescale 1ns / 1ps

module pcb_blend_checker (
  input  logic clk_i,
  input  logic rst_ni,
  pcb_in_if    req_i,
  pcb_out_if   res_i,
  output int   fail_count_o,
  output int   pending_o,
  output int   checked_o,
  output int   untouched_o
);
  import pcb_pkg::*;

  typedef struct packed {
    pixel_t pixel;
    logic   written;
  } blend_result_t;

  blend_result_t blend_expect_q[$];

  // a * b / 255, truncating
  function automatic logic [7:0] scale_alpha(logic [7:0] a, logic [7:0] b);
    int unsigned prod;
    prod = int'(a) * int'(b);
    return 8'(prod / 255);
  endfunction

  function automatic logic [7:0] mix_byte(logic [7:0] s, logic [7:0] d, logic [7:0] a);
    int unsigned acc;
    acc = int'(s) * int'(a) + int'(d) * (255 - int'(a));
    return 8'(acc / 255);
  endfunction

  function automatic blend_result_t composite_over(cmd_e cmd, pixel_t dst, pixel_t tex,
                                                   logic [31:0] argb, logic [7:0] cov);
    logic [7:0]    paint_a;
    logic [7:0]    src_a;
    pixel_t        paint;
    pixel_t        src;
    blend_result_t r;
    paint_a = (argb[31:24] == AlphaClear) ? AlphaOpaque : argb[31:24];
    paint   = {paint_a, argb[7:0], argb[15:8], argb[23:16]};
    case (cmd)
      CmdSolid: src = paint;
      CmdTexel: src = tex;
      CmdTint:  src = {scale_alpha(tex[31:24], paint_a), paint[23:0]};
      default:  src = {scale_alpha(cov, paint_a), paint[23:0]};
    endcase
    src_a = src[31:24];
    if (src_a == AlphaClear) begin
      r.pixel   = dst;
      r.written = 1'b0;
    end else if (src_a == AlphaOpaque) begin
      r.pixel   = src;
      r.written = 1'b1;
    end else begin
      r.pixel   = {AlphaOpaque,
                   mix_byte(src[23:16], dst[23:16], src_a),
                   mix_byte(src[15:8],  dst[15:8],  src_a),
                   mix_byte(src[7:0],   dst[7:0],   src_a)};
      r.written = 1'b1;
    end
    return r;
  endfunction

  task automatic report_mismatch(string what);
    $display("[%0t] blend mismatch: %s", $time, what);
    fail_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    blend_result_t got;
    blend_result_t want;
    if (!rst_ni) begin
      blend_expect_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
      checked_o    = 0;
      untouched_o  = 0;
    end else begin
      if (req_i.valid && req_i.ready) begin
        blend_expect_q.push_back(composite_over(cmd_e'(req_i.command), req_i.dest_pixel,
                                                req_i.texel, req_i.color, req_i.coverage));
      end
      if (res_i.valid && res_i.ready) begin
        got = {res_i.pixel_out, res_i.written};
        if (blend_expect_q.size() == 0) begin
          report_mismatch($sformatf("result %08h written %b with no request outstanding",
                                    got.pixel, got.written));
        end else begin
          want = blend_expect_q.pop_front();
          checked_o++;
          if (!want.written) untouched_o++;
          if (got.pixel !== want.pixel)
            report_mismatch($sformatf("pixel_out %08h, want %08h", got.pixel, want.pixel));
          if (got.written !== want.written)
            report_mismatch($sformatf("written %b, want %b (pixel %08h)",
                                      got.written, want.written, want.pixel));
        end
      end
      pending_o = blend_expect_q.size();
    end
  end

endmodule

>>> tb/pixel_compositing_blend_unit_tb.sv
// Testbench top: drives requests and result back-pressure, and reports the verdict.
`timescale 1ns / 1ps

module pixel_compositing_blend_unit_tb;
  import pcb_pkg::*;

  localparam int LatencyCycles = 4;
  localparam int HoldCycles    = 48;       // long sink hold-off, well past pipeline depth
  localparam int CycleLimit    = 200000;   // watchdog limit, well above the slowest legal run

  logic clk_i = 1'b0;
  logic rst_ni;

  pcb_in_if  req_ch ();
  pcb_out_if res_ch ();

  int fail_count;
  int pending;
  int checked;
  int untouched;
  int cycle_count = 0;
  int sent_per_cmd [4];
  bit idle_en;          // random gaps on both sides while set
  int hold_asked = 0;   // bumped by the stimulus to request one long sink hold-off

  pixel_compositing_blend_unit i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_ch),
    .out_o  (res_ch)
  );

  pcb_blend_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_ch),
    .res_i        (res_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked),
    .untouched_o  (untouched)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Watchdog: anything that hangs the handshake ends up here.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("pixel_compositing_blend_unit_tb: errors");
      $finish;
    end
  end

  // Byte picker biased towards the alpha corners: clear, opaque and their neighbours.
  function automatic logic [7:0] pick_alpha();
    case ($urandom_range(0, 9))
      0:       return AlphaClear;
      1:       return AlphaOpaque;
      2:       return 8'h01;
      3:       return 8'hfe;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Offer one request; entered and left on a falling edge. Valid stays high between
  // back-to-back requests, so it is only written once per time step.
  task automatic send_request(cmd_e cmd, pixel_t dst, pixel_t tex, logic [31:0] argb,
                              logic [7:0] cov);
    int gap;
    if (idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 3);
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_ch.valid      <= 1'b1;
    req_ch.command    <= cmd;
    req_ch.dest_pixel <= dst;
    req_ch.texel      <= tex;
    req_ch.color      <= argb;
    req_ch.coverage   <= cov;
    @(posedge clk_i);
    while (!req_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
    sent_per_cmd[cmd]++;
  endtask

  task automatic send_random(int count);
    cmd_e        cmd;
    pixel_t      dst;
    logic [31:0] tex;
    logic [31:0] argb;
    repeat (count) begin
      cmd  = cmd_e'($urandom_range(0, 3));
      dst  = $urandom;
      tex  = {pick_alpha(), 24'($urandom)};
      argb = {pick_alpha(), 24'($urandom)};
      // now and then make the source colour match the destination, so a partial blend
      // gives back the pixel it started from
      if ($urandom_range(0, 15) == 0) begin
        if (cmd == CmdTexel) dst[23:0] = tex[23:0];
        else                 dst[23:0] = {argb[7:0], argb[15:8], argb[23:16]};
        dst[31:24] = AlphaOpaque;
      end
      send_request(cmd, dst, tex, argb, pick_alpha());
    end
  endtask

  // Stop offering and wait for the pipeline to hand back everything outstanding.
  task automatic drain_pipeline();
    req_ch.valid <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
  endtask

  // Result side: random short stalls, plus one long hold-off when asked.
  initial begin
    int stall_left;
    int hold_left;
    int hold_seen;
    stall_left = 0;
    hold_left  = 0;
    hold_seen  = 0;
    res_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_seen != hold_asked) begin
        hold_seen = hold_asked;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        res_ch.ready <= 1'b0;
      end else if (idle_en && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(0, 2);   // start a burst of stalls, this one included; stall_left counts the rest
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    // everything known from time zero, with reset held low at the start
    rst_ni            = 1'b0;
    idle_en           = 1'b0;
    req_ch.valid      = 1'b0;
    req_ch.command    = CmdSolid;
    req_ch.dest_pixel = '0;
    req_ch.texel      = '0;
    req_ch.color      = '0;
    req_ch.coverage   = '0;
    foreach (sent_per_cmd[i]) sent_per_cmd[i] = 0;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    idle_en = 1'b1;

    // Directed: solid colour, script alpha of zero reads as opaque
    send_request(CmdSolid, 32'h8040_2010, '0, 32'h0012_3456, 8'h00);
    send_request(CmdSolid, 32'h0000_0000, '0, 32'hff_ffffff, 8'hff);
    send_request(CmdSolid, 32'hffff_ffff, '0, 32'h80_00ff00, 8'h00);
    send_request(CmdSolid, 32'h1234_5678, '0, 32'h01_ffffff, 8'h00);
    send_request(CmdSolid, 32'h1234_5678, '0, 32'hfe_000000, 8'h00);
    // partial alpha over a matching opaque pixel: same value, still written
    send_request(CmdSolid, 32'hff30_2010, '0, 32'h7f_102030, 8'h00);

    // plain texel: clear, opaque, half, extremes of destination
    send_request(CmdTexel, 32'h8040_2010, 32'h00ff_ffff, 32'hff_ffffff, 8'hff);
    send_request(CmdTexel, 32'h0000_0000, 32'hffab_cdef, 32'h00_000000, 8'h00);
    send_request(CmdTexel, 32'hffff_ffff, 32'h8000_0000, 32'h00_000000, 8'h00);
    send_request(CmdTexel, 32'h0000_0000, 32'h80ff_ffff, 32'h00_000000, 8'h00);
    send_request(CmdTexel, 32'hff30_2010, 32'h4030_2010, 32'h00_000000, 8'h00);

    // tinted texel: texel alpha zero skips, alpha product can truncate to zero
    send_request(CmdTint, 32'h8040_2010, 32'h00ff_ffff, 32'hff_ffffff, 8'h00);
    send_request(CmdTint, 32'h8040_2010, 32'hff00_0000, 32'hff_a0b0c0, 8'h00);
    send_request(CmdTint, 32'h8040_2010, 32'h8012_3456, 32'h00_a0b0c0, 8'h00);
    send_request(CmdTint, 32'hffff_ffff, 32'h0100_0000, 32'h01_000000, 8'h00);
    send_request(CmdTint, 32'h0000_0000, 32'hfe00_0000, 32'hfe_ffffff, 8'hff);

    // glyph coverage: zero skips, full coverage with default alpha replaces
    send_request(CmdGlyph, 32'h8040_2010, 32'hffff_ffff, 32'hff_ffffff, 8'h00);
    send_request(CmdGlyph, 32'h8040_2010, '0, 32'h00_112233, 8'hff);
    send_request(CmdGlyph, 32'h0000_0000, '0, 32'h80_ffffff, 8'h80);
    send_request(CmdGlyph, 32'hffff_ffff, '0, 32'h01_000000, 8'h01);
    send_request(CmdGlyph, 32'hff33_2211, '0, 32'hff_112233, 8'h7f);

    send_random(160);

    // sink holds off for a long stretch while the sender keeps offering: input stalls
    hold_asked++;
    send_random(60);

    // sender pause until everything has come back
    drain_pipeline();
    send_random(150);

    // closing stretch at full rate on both sides
    idle_en = 1'b0;
    send_random(60);

    drain_pipeline();
    repeat (2 * LatencyCycles) @(negedge clk_i);

    $display("covered %0d requests: solid %0d, texel %0d, tinted %0d, glyph %0d",
             sent_per_cmd[CmdSolid] + sent_per_cmd[CmdTexel] + sent_per_cmd[CmdTint]
               + sent_per_cmd[CmdGlyph],
             sent_per_cmd[CmdSolid], sent_per_cmd[CmdTexel], sent_per_cmd[CmdTint],
             sent_per_cmd[CmdGlyph]);
    $display("%0d results compared, %0d left the pixel untouched, %0d mismatches",
             checked, untouched, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("pixel_compositing_blend_unit_tb: clean");
    end else begin
      $display("pixel_compositing_blend_unit_tb: errors");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/pcb_pkg.sv
rtl/core/pcb_if.sv
rtl/core/pcb_mix.sv
rtl/core/pixel_compositing_blend_unit.sv
rtl/core/pcb_checker.sv
tb/pcb_blend_checker.sv
tb/pixel_compositing_blend_unit_tb.sv
